[hdl/tsafc_pkg.sv]
package tsafc_pkg;

   // Built geometry
   localparam int MAX_SETS = 64;
   localparam int WAYS     = 2;
   localparam int SET_W    = $clog2(MAX_SETS);
   localparam int WAY_W    = 1;

   // Field widths
   localparam int ADDR_W      = 32;
   localparam int BLOCK_W     = 32;
   localparam int CNT_W       = 32;
   localparam int SET_INDEX_W = 6;
   localparam int SHIFT_W     = 4;
   localparam int SETLOG_W    = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   // Reset values of the control registers
   localparam logic [SHIFT_W-1:0]  BLOCK_SHIFT_RST    = SHIFT_W'(2);
   localparam logic [SETLOG_W-1:0] SET_COUNT_LOG2_RST = SETLOG_W'(6);

   // Control register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_SHIFT    = 2'd0,
      CSR_SET_COUNT_LOG2 = 2'd1
   } tsafc_csr_idx_type;

   typedef logic [WAYS-1:0][BLOCK_W-1:0] tsafc_row_type;

   // Tag store write: whole row of one set
   typedef struct packed {
      logic                en;
      logic [SET_W-1:0]    set;
      logic [WAY_W-1:0]    way;
      tsafc_row_type       row;
   } tsafc_wr_type;

   // Tag store lookup view of one set
   typedef struct packed {
      tsafc_row_type       block;
      logic [WAYS-1:0]     valid;
      logic [WAY_W-1:0]    victim;
   } tsafc_look_type;

endpackage

[hdl/tsafc_ifs.sv]
interface tsafc_req_if;
   logic                        valid;
   logic                        ready;
   logic [tsafc_pkg::ADDR_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

interface tsafc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             hit;
   logic [tsafc_pkg::SET_INDEX_W-1:0] set_index;
   logic [tsafc_pkg::CNT_W-1:0]       hit_total;
   logic [tsafc_pkg::CNT_W-1:0]       miss_total;

   modport source (output valid, output hit, output set_index, output hit_total,
                   output miss_total, input ready);
   modport sink   (input valid, input hit, input set_index, input hit_total,
                   input miss_total, output ready);
endinterface

interface tsafc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tsafc_pkg::CSR_IDX_W-1:0]  index;
   logic [tsafc_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/tsafc_tag_store.sv]
module tsafc_tag_store (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [tsafc_pkg::SET_W-1:0]      rd_set,
   input  logic [tsafc_pkg::SET_W-1:0]      lk_set,
   input  tsafc_pkg::tsafc_wr_type          wr,
   output tsafc_pkg::tsafc_look_type        look
);
   import tsafc_pkg::*;

   tsafc_row_type                   mem [MAX_SETS];
   tsafc_row_type                   rd_row_ff;
   tsafc_row_type                   byp_row_ff;
   logic                            byp_hit_ff;
   logic [MAX_SETS-1:0][WAYS-1:0]   valid_ff;
   logic [MAX_SETS-1:0]             ptr_ff;

   // Tag memory: one row write, one registered row read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.set] <= wr.row;
      end
      if (rd_en) begin
         rd_row_ff  <= mem[rd_set];
         byp_row_ff <= wr.row;
      end
   end

   // Flag a read that collides with the row being written in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_hit_ff <= 1'b0;
      end else if (rd_en) begin
         byp_hit_ff <= wr.en && (wr.set == rd_set);
      end
   end

   // Valid bits and replacement pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
      end else if (wr.en) begin
         valid_ff[wr.set][wr.way] <= 1'b1;
         ptr_ff[wr.set]           <= ~wr.way;
      end
   end

   // Present the set under lookup
   always_comb begin
      look.block  = byp_hit_ff ? byp_row_ff : rd_row_ff;
      look.valid  = valid_ff[lk_set];
      look.victim = ptr_ff[lk_set];
   end

endmodule

[hdl/two_way_set_assoc_fifo_cache.sv]
// Hit/miss tracker for a two-way set-associative cache with round-robin
// (FIFO) replacement per set. One address word is accepted every cycle unless
// the output side stalls; its result word passes the lookup register and the
// result register, and a taken result frees room for the next word in the
// same cycle. The tag RAM is read at acceptance and compared in the following
// cycle, where a miss writes the victim way back; a read that meets a write
// to the same set takes the written row instead. Valid bits and pointers sit
// in flip-flops cleared by reset, so no clearing pass is needed. Write the
// block shift and set count registers only while the block is empty.
module two_way_set_assoc_fifo_cache (
   input  logic         clock,
   input  logic         reset,
   tsafc_req_if.sink    req_if,
   tsafc_rsp_if.source  rsp_if,
   tsafc_csr_if.sink    csr_if
);
   import tsafc_pkg::*;

   logic [SHIFT_W-1:0]   block_shift_ff;
   logic [SETLOG_W-1:0]  set_count_log2_ff;

   logic                 s1_valid_ff;
   logic [BLOCK_W-1:0]   s1_block_ff;
   logic [SET_W-1:0]     s1_set_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [SET_W-1:0]     rsp_set_ff;
   logic [CNT_W-1:0]     hit_cnt_ff;
   logic [CNT_W-1:0]     miss_cnt_ff;
   logic [CNT_W-1:0]     hit_cnt_in;
   logic [CNT_W-1:0]     miss_cnt_in;

   logic [BLOCK_W-1:0]   req_block;
   logic [SETLOG_W-1:0]  sets_log2;
   logic [SET_W-1:0]     set_mask;
   logic [SET_W-1:0]     req_set;
   logic                 accept;
   logic                 s1_go;
   logic [WAYS-1:0]      way_hit;
   logic                 hit;
   tsafc_wr_type         wr;
   tsafc_look_type       look;

   // Control registers
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_shift_ff    <= BLOCK_SHIFT_RST;
         set_count_log2_ff <= SET_COUNT_LOG2_RST;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_BLOCK_SHIFT:    block_shift_ff    <= csr_if.data[SHIFT_W-1:0];
            CSR_SET_COUNT_LOG2: set_count_log2_ff <= csr_if.data[SETLOG_W-1:0];
            default: ;
         endcase
      end
   end

   // Map the incoming address to block number and set
   always_comb begin
      req_block = BLOCK_W'(req_if.address >> block_shift_ff);
      sets_log2 = (int'(set_count_log2_ff) > SET_W) ? SETLOG_W'(SET_W) : set_count_log2_ff;
      set_mask  = ~({SET_W{1'b1}} << sets_log2);
      req_set   = req_block[SET_W-1:0] & set_mask;
   end

   // Handshake: the lookup stage moves when the result register has room
   assign s1_go        = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_go;
   assign accept       = req_if.valid && req_if.ready;

   tsafc_tag_store u_store (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (accept),
      .rd_set (req_set),
      .lk_set (s1_set_ff),
      .wr     (wr),
      .look   (look)
   );

   // Compare both ways, build the fill row on a miss
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         way_hit[w] = look.valid[w] && (look.block[w] == s1_block_ff);
      end
      hit    = |way_hit;
      wr.en  = s1_go && !hit;
      wr.set = s1_set_ff;
      wr.way = look.victim;
      wr.row = look.block;
      wr.row[look.victim] = s1_block_ff;
   end

   // Saturating totals
   always_comb begin
      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      if (hit) begin
         if (hit_cnt_ff != {CNT_W{1'b1}}) hit_cnt_in = hit_cnt_ff + CNT_W'(1);
      end else begin
         if (miss_cnt_ff != {CNT_W{1'b1}}) miss_cnt_in = miss_cnt_ff + CNT_W'(1);
      end
   end

   // Lookup stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_block_ff <= req_block;
         s1_set_ff   <= req_set;
      end
   end

   // Counters advance as each word commits
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
      end else if (s1_go) begin
         hit_cnt_ff  <= hit_cnt_in;
         miss_cnt_ff <= miss_cnt_in;
      end
   end

   // Result register: load on commit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_hit_ff <= hit;
         rsp_set_ff <= s1_set_ff;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.hit        = rsp_hit_ff;
   assign rsp_if.set_index  = SET_INDEX_W'(rsp_set_ff);
   assign rsp_if.hit_total  = hit_cnt_ff;
   assign rsp_if.miss_total = miss_cnt_ff;

endmodule

[hdl/tsafc_checker.sv]
module tsafc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_hit,
   input logic [tsafc_pkg::CNT_W-1:0]        rsp_hit_total,
   input logic [tsafc_pkg::CNT_W-1:0]        rsp_miss_total
);
   import tsafc_pkg::*;

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit_total)
                                  && $stable(rsp_miss_total))
      else $error("result word dropped or changed while stalled");

   // No result right after reset
   a_rsp_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word valid right after reset");

   // A shown total includes the word itself
   a_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit ? (rsp_hit_total != '0) : (rsp_miss_total != '0)))
      else $error("total does not count the current word");

   // Back-to-back hit words: hit total steps by one, miss total holds
   a_hit_step: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid && rsp_ready) && rsp_valid && rsp_hit |->
         ((rsp_hit_total == CNT_W'($past(rsp_hit_total) + CNT_W'(1)))
          || (rsp_hit_total == {CNT_W{1'b1}}))
         && (rsp_miss_total == $past(rsp_miss_total)))
      else $error("hit total did not advance by one");

   // Back-to-back miss words: miss total steps by one, hit total holds
   a_miss_step: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid && rsp_ready) && rsp_valid && !rsp_hit |->
         ((rsp_miss_total == CNT_W'($past(rsp_miss_total) + CNT_W'(1)))
          || (rsp_miss_total == {CNT_W{1'b1}}))
         && (rsp_hit_total == $past(rsp_hit_total)))
      else $error("miss total did not advance by one");

endmodule

bind two_way_set_assoc_fifo_cache tsafc_checker u_tsafc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_hit        (rsp_if.hit),
   .rsp_hit_total  (rsp_if.hit_total),
   .rsp_miss_total (rsp_if.miss_total)
);

[verif/tb_two_way_set_assoc_fifo_cache.sv]
module tb_two_way_set_assoc_fifo_cache;
   timeunit 1ns;
   timeprecision 1ps;
   import tsafc_pkg::*;

   // Register indexes outside the map; writes to them must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam int PHASES     = 9;
   localparam int PHASE_WORDS = 200;
   localparam int POOL_SIZE  = 8;

   typedef struct packed {
      logic                   hit;
      logic [SET_INDEX_W-1:0] set_index;
      logic [CNT_W-1:0]       hit_total;
      logic [CNT_W-1:0]       miss_total;
   } lookup_result_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tsafc_req_if req_if ();
   tsafc_rsp_if rsp_if ();
   tsafc_csr_if csr_if ();

   two_way_set_assoc_fifo_cache dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always #1 clock = ~clock;

   // Mirror of the tag store, pointers, totals and registers
   logic [BLOCK_W-1:0]  tag_mirror [MAX_SETS][WAYS];
   logic                tag_live [MAX_SETS][WAYS];
   logic                fifo_ptr [MAX_SETS];
   logic [CNT_W-1:0]    hits_seen;
   logic [CNT_W-1:0]    misses_seen;
   logic [SHIFT_W-1:0]  blk_shift;
   logic [SETLOG_W-1:0] set_log2;

   lookup_result_type   lookup_results_due [$];
   logic [ADDR_W-1:0]   address_queue [$];
   csr_word_type        csr_words [$];
   logic [ADDR_W-1:0]   hot_addr [POOL_SIZE];
   logic [ADDR_W-1:0]   last_addr;

   int                  sender_idle_pct;
   int                  receiver_stall_pct;
   logic                sender_hold;
   int                  mismatch_count;

   task automatic report_mismatch(string field, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
      $display("%0t lookup error on %s: got %0h want %0h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   // Look up one address in the mirror, fill on a miss, return the result word
   function automatic lookup_result_type cache_lookup(logic [ADDR_W-1:0] address);
      logic [BLOCK_W-1:0] blk;
      logic [BLOCK_W-1:0] mask;
      int                 k;
      int                 set_sel;
      logic               found;
      logic               victim;
      lookup_result_type  r;
      blk = address >> blk_shift;
      k = (set_log2 > SET_W) ? SET_W : int'(set_log2);
      mask = (32'd1 << k) - 32'd1;
      set_sel = int'(blk & mask);
      found = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         if (tag_live[set_sel][w] && tag_mirror[set_sel][w] == blk) found = 1'b1;
      end
      if (found) begin
         if (hits_seen != '1) hits_seen++;
      end else begin
         victim = fifo_ptr[set_sel];
         tag_mirror[set_sel][victim] = blk;
         tag_live[set_sel][victim] = 1'b1;
         fifo_ptr[set_sel] = ~victim;
         if (misses_seen != '1) misses_seen++;
      end
      r.hit = found;
      r.set_index = set_sel[SET_INDEX_W-1:0];
      r.hit_total = hits_seen;
      r.miss_total = misses_seen;
      return r;
   endfunction

   // Drive the request channel from the address queue
   always @(posedge clock) begin
      logic go;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         go = address_queue.size() != 0 && !sender_hold &&
              ($urandom_range(0, 99) >= sender_idle_pct);
         if (go) req_if.address <= address_queue.pop_front();
         req_if.valid <= go;
      end
   end

   // Drive the register write channel
   always @(posedge clock) begin
      csr_word_type cw;
      if (reset) begin
         csr_if.valid <= 1'b0;
      end else if (!csr_if.valid || csr_if.ready) begin
         if (csr_words.size() != 0) begin
            cw = csr_words.pop_front();
            csr_if.index <= cw.index;
            csr_if.data <= cw.data;
            csr_if.valid <= 1'b1;
         end else begin
            csr_if.valid <= 1'b0;
         end
      end
   end

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_if.ready <= !reset && ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // Track register writes, predict accepted words, check returned words
   always @(posedge clock) begin
      lookup_result_type got;
      lookup_result_type want;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) begin
            if (csr_if.index == CSR_BLOCK_SHIFT) blk_shift = csr_if.data[SHIFT_W-1:0];
            else if (csr_if.index == CSR_SET_COUNT_LOG2) set_log2 = csr_if.data[SETLOG_W-1:0];
         end
         if (req_if.valid && req_if.ready) lookup_results_due.push_back(cache_lookup(req_if.address));
         if (rsp_if.valid && rsp_if.ready) begin
            got.hit = rsp_if.hit;
            got.set_index = rsp_if.set_index;
            got.hit_total = rsp_if.hit_total;
            got.miss_total = rsp_if.miss_total;
            if (lookup_results_due.size() == 0) begin
               report_mismatch("unrequested word", CNT_W'(got.set_index), '0);
            end else begin
               want = lookup_results_due.pop_front();
               if (got.hit !== want.hit)
                  report_mismatch("hit", CNT_W'(got.hit), CNT_W'(want.hit));
               if (got.set_index !== want.set_index)
                  report_mismatch("set_index", CNT_W'(got.set_index), CNT_W'(want.set_index));
               if (got.hit_total !== want.hit_total)
                  report_mismatch("hit_total", got.hit_total, want.hit_total);
               if (got.miss_total !== want.miss_total)
                  report_mismatch("miss_total", got.miss_total, want.miss_total);
            end
         end
      end
   end

   // Hold until every queued word has gone through and its result came back
   task automatic drain();
      while (address_queue.size() != 0 || req_if.valid || lookup_results_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write both registers plus one unmapped index, with junk in the upper bits
   task automatic write_config(logic [SHIFT_W-1:0] shift, logic [SETLOG_W-1:0] slog,
                               logic [CSR_IDX_W-1:0] spare);
      csr_word_type cw;
      cw.index = CSR_BLOCK_SHIFT;
      cw.data = CSR_DATA_W'($urandom);
      cw.data[SHIFT_W-1:0] = shift;
      csr_words.push_back(cw);
      cw.index = CSR_SET_COUNT_LOG2;
      cw.data = CSR_DATA_W'($urandom);
      cw.data[SETLOG_W-1:0] = slog;
      csr_words.push_back(cw);
      cw.index = spare;
      cw.data = CSR_DATA_W'($urandom);
      csr_words.push_back(cw);
      while (csr_words.size() != 0 || csr_if.valid) @(negedge clock);
   endtask

   // Rebuild some or all of the hot pool: two groups of blocks that share a set
   task automatic refresh_pool(int count);
      logic [ADDR_W-1:0] base_a;
      logic [ADDR_W-1:0] base_b;
      logic [ADDR_W-1:0] base;
      int                k;
      int                start;
      int                idx;
      k = (set_log2 > SET_W) ? SET_W : int'(set_log2);
      base_a = $urandom;
      base_b = $urandom;
      start = $urandom_range(0, POOL_SIZE - 1);
      for (int i = 0; i < count; i++) begin
         idx = (start + i) % POOL_SIZE;
         base = (i % 2 == 0) ? base_a : base_b;
         hot_addr[idx] = (i < 2) ? base : base ^ (ADDR_W'($urandom) << (blk_shift + k));
      end
   endtask

   // Mostly pool blocks with a random byte offset, some repeats, some noise
   function automatic logic [ADDR_W-1:0] next_address();
      int                pick;
      logic [ADDR_W-1:0] a;
      pick = $urandom_range(0, 99);
      if (pick < 65)
         a = hot_addr[$urandom_range(0, POOL_SIZE - 1)] ^
             (ADDR_W'($urandom) & ((32'd1 << blk_shift) - 32'd1));
      else if (pick < 80)
         a = last_addr;
      else
         a = $urandom;
      last_addr = a;
      return a;
   endfunction

   // Random words for one phase, with one full pause of the sender midway
   task automatic run_phase();
      for (int i = 0; i < PHASE_WORDS; i++) address_queue.push_back(next_address());
      while (address_queue.size() > PHASE_WORDS / 2) @(negedge clock);
      sender_hold = 1'b1;
      while (req_if.valid || lookup_results_due.size() != 0) @(negedge clock);
      sender_hold = 1'b0;
      drain();
   endtask

   initial begin
      int                shift_plan [PHASES];
      int                slog_plan [PHASES];
      logic [ADDR_W-1:0] directed [$];

      shift_plan = '{2, 0, 15, 12, 4, 2, 7, 1, 3};
      slog_plan  = '{6, 0, 7, 6, 3, 6, 1, 5, 2};
      // Eviction order in set 0, byte offsets in one block, all-ones and checkerboards
      directed = '{32'h0000_0000, 32'h0000_0003, 32'h0000_0100, 32'h0000_0000,
                   32'h0000_0200, 32'h0000_0100, 32'h0000_0000, 32'h0000_0100,
                   32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'h7FFF_FFFC, 32'h8000_0000,
                   32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAA8,
                   32'h0000_0200, 32'h8000_0000};

      // Start from reset state with every input known
      for (int s = 0; s < MAX_SETS; s++) begin
         fifo_ptr[s] = 1'b0;
         for (int w = 0; w < WAYS; w++) tag_live[s][w] = 1'b0;
      end
      hits_seen = '0;
      misses_seen = '0;
      blk_shift = BLOCK_SHIFT_RST;
      set_log2 = SET_COUNT_LOG2_RST;
      mismatch_count = 0;
      sender_hold = 1'b0;
      sender_idle_pct = 9;
      receiver_stall_pct = 82;
      last_addr = '0;
      req_if.valid = 1'b0;
      req_if.address = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_BLOCK_SHIFT;
      csr_if.data = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      refresh_pool(POOL_SIZE);
      foreach (directed[i]) address_queue.push_back(directed[i]);
      drain();

      // Walk the register settings; idle pattern changes every third phase
      for (int p = 0; p < PHASES; p++) begin
         case (p / 3)
            0: begin
               sender_idle_pct = 9;
               receiver_stall_pct = 82;
            end
            1: begin
               sender_idle_pct = 82;
               receiver_stall_pct = 9;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
         endcase
         if (p != 0) begin
            write_config(SHIFT_W'(shift_plan[p]), SETLOG_W'(slog_plan[p]),
                         (p % 2 == 0) ? CSR_SPARE_LO : CSR_SPARE_HI);
            refresh_pool(POOL_SIZE - 2);
         end
         run_phase();
      end

      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
